### rtl/core/nnr_pkg.sv
package nnr_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_HEIGHT = 3'd3;

   // register and field widths
   localparam int SRC_W    = 9;
   localparam int DST_W    = 13;
   localparam int COORD_W  = 12;
   localparam int PLANE_W  = 2;
   localparam int SAMPLE_W = 16;

   localparam logic [SRC_W-1:0] SRC_RESET = 9'd256;
   localparam logic [DST_W-1:0] DST_RESET = 13'd256;

   // coordinate mapping divider
   localparam int PROD_W    = COORD_W + SRC_W;
   localparam int REM_W     = DST_W + 1;
   localparam int DIV_CNT_W = $clog2(PROD_W + 1);

   localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(PROD_W);

endpackage

### rtl/core/nnr_if.sv
interface nnr_req_if;
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic [nnr_pkg::COORD_W-1:0]  col;
   logic [nnr_pkg::COORD_W-1:0]  row;
   logic [nnr_pkg::PLANE_W-1:0]  plane;
   logic [nnr_pkg::SAMPLE_W-1:0] sample_in;

   modport source (output valid, mode, col, row, plane, sample_in, input ready);
   modport sink (input valid, mode, col, row, plane, sample_in, output ready);
endinterface

interface nnr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [nnr_pkg::SAMPLE_W-1:0] sample_out;

   modport source (output valid, sample_out, input ready);
   modport sink (input valid, sample_out, output ready);
endinterface

### rtl/core/nnr_map.sv
module nnr_map (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [nnr_pkg::COORD_W-1:0] d,
   input  logic [nnr_pkg::SRC_W-1:0]   src,
   input  logic [nnr_pkg::DST_W-1:0]   dst,
   output logic                        done,
   output logic [nnr_pkg::SRC_W-1:0]   coord
);
   import nnr_pkg::*;

   typedef enum logic [2:0] {
      M_IDLE = 3'b001,
      M_MUL  = 3'b010,
      M_DIV  = 3'b100
   } map_state_type;

   map_state_type          state_ff, state_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   done_ff, done_in;
   logic [COORD_W-1:0]     d_ff, d_in;
   logic [SRC_W-1:0]       num_ff, num_in;
   logic [SRC_W-1:0]       lim_ff, lim_in;
   logic [DST_W-1:0]       dst_ff, dst_in;
   logic [PROD_W-1:0]      quo_ff, quo_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [SRC_W-1:0]       coord_ff, coord_in;

   logic [REM_W-1:0]       trial;
   logic                   fits;
   logic [REM_W-1:0]       rem_step;
   logic [PROD_W-1:0]      quo_step;

   // one restoring division step per cycle
   assign trial    = {rem_ff[REM_W-2:0], quo_ff[PROD_W-1]};
   assign fits     = trial >= {1'b0, dst_ff};
   assign rem_step = fits ? trial - {1'b0, dst_ff} : trial;
   assign quo_step = {quo_ff[PROD_W-2:0], fits};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      d_in     = d_ff;
      num_in   = num_ff;
      lim_in   = lim_ff;
      dst_in   = dst_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      coord_in = coord_ff;
      case (state_ff)
         M_IDLE: begin
            if (start) begin
               d_in     = d;
               // shrinking uses src - 1 as the numerator
               num_in   = ({4'b0, src} <= dst) ? src : src - 1'b1;
               lim_in   = src - 1'b1;
               dst_in   = dst;
               state_in = M_MUL;
            end
         end
         M_MUL: begin
            quo_in   = PROD_W'(d_ff) * PROD_W'(num_ff);
            rem_in   = '0;
            cnt_in   = DIV_STEPS;
            state_in = M_DIV;
         end
         M_DIV: begin
            quo_in = quo_step;
            rem_in = rem_step;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               coord_in = (quo_step > PROD_W'(lim_ff)) ? lim_ff : quo_step[SRC_W-1:0];
               done_in  = 1'b1;
               state_in = M_IDLE;
            end
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff     <= d_in;
      num_ff   <= num_in;
      lim_ff   <= lim_in;
      dst_ff   <= dst_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      coord_ff <= coord_in;
   end

   assign done  = done_ff;
   assign coord = coord_ff;

endmodule

### rtl/core/nearest_neighbor_resize.sv
// loads: written straight into the frame store, no response; taken only while idle
// queries: both coordinates are mapped, the frame store is read, and the response is
// registered once the output register is free; no further request is taken until then
// the query time is set by the bit-serial divider mapping each coordinate (21 steps)
// synchronous active-high reset clears control and sets the size registers to 256;
// frame store contents are undefined until written
module nearest_neighbor_resize #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int CHANNELS   = 3,
   parameter int PIXEL_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   nnr_req_if.sink                        req_ch,
   nnr_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [nnr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [nnr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import nnr_pkg::*;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_DIV  = 4'b0010,
      S_READ = 4'b0100,
      S_DATA = 4'b1000
   } state_type;

   // size registers
   logic [SRC_W-1:0] src_w_ff, src_w_in;
   logic [SRC_W-1:0] src_h_ff, src_h_in;
   logic [DST_W-1:0] dst_w_ff, dst_w_in;
   logic [DST_W-1:0] dst_h_ff, dst_h_in;

   logic [SRC_W-1:0] sw, sh;
   logic [DST_W-1:0] tw, th;

   state_type              state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [PLANE_W-1:0]     plane_ff, plane_in;
   logic                   bad_plane_ff, bad_plane_in;

   logic [PIXEL_BITS-1:0]  mem [DEPTH];
   logic [PIXEL_BITS-1:0]  rdata_ff;
   logic [31:0]            rdata_wide;

   logic                   req_fire;
   logic                   load_ok;
   logic                   wr_en;
   logic                   rd_en;
   logic                   map_start;
   logic                   x_done, y_done;
   logic [SRC_W-1:0]       sx, sy;
   logic [31:0]            wr_addr_full;
   logic [31:0]            rd_addr_full;
   logic                   rsp_free;

   // effective sizes: zero acts as one, source capped at the store size
   always_comb begin
      sw = (src_w_ff == '0) ? SRC_W'(1) :
           ({4'b0, src_w_ff} > 13'(MAX_WIDTH)) ? SRC_W'(MAX_WIDTH) : src_w_ff;
      sh = (src_h_ff == '0) ? SRC_W'(1) :
           ({4'b0, src_h_ff} > 13'(MAX_HEIGHT)) ? SRC_W'(MAX_HEIGHT) : src_h_ff;
      tw = (dst_w_ff == '0) ? DST_W'(1) : dst_w_ff;
      th = (dst_h_ff == '0) ? DST_W'(1) : dst_h_ff;
   end

   always_comb begin
      src_w_in = src_w_ff;
      src_h_in = src_h_ff;
      dst_w_in = dst_w_ff;
      dst_h_in = dst_h_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SOURCE_WIDTH:  src_w_in = csr_wdata[SRC_W-1:0];
            CSR_SOURCE_HEIGHT: src_h_in = csr_wdata[SRC_W-1:0];
            CSR_TARGET_WIDTH:  dst_w_in = csr_wdata;
            CSR_TARGET_HEIGHT: dst_h_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign load_ok = ({1'b0, req_ch.col} < 13'(sw)) && ({1'b0, req_ch.row} < 13'(sh)) &&
                    (32'(req_ch.plane) < 32'(CHANNELS));
   assign wr_en   = req_fire && !req_ch.mode && load_ok;

   assign wr_addr_full = (32'(req_ch.plane) * 32'(MAX_HEIGHT) + 32'(req_ch.row)) *
                         32'(MAX_WIDTH) + 32'(req_ch.col);
   assign rd_addr_full = (32'(plane_ff) * 32'(MAX_HEIGHT) + 32'(sy)) *
                         32'(MAX_WIDTH) + 32'(sx);

   assign map_start = req_fire && req_ch.mode;
   assign rd_en     = (state_ff == S_READ) && !bad_plane_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ch.ready;

   nnr_map u_map_x (
      .clock (clock),
      .reset (reset),
      .start (map_start),
      .d     (req_ch.col),
      .src   (sw),
      .dst   (tw),
      .done  (x_done),
      .coord (sx)
   );

   nnr_map u_map_y (
      .clock (clock),
      .reset (reset),
      .start (map_start),
      .d     (req_ch.row),
      .src   (sh),
      .dst   (th),
      .done  (y_done),
      .coord (sy)
   );

   assign rdata_wide = 32'(rdata_ff);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      plane_in     = plane_ff;
      bad_plane_in = bad_plane_ff;
      case (state_ff)
         S_IDLE: begin
            if (map_start) begin
               plane_in     = req_ch.plane;
               bad_plane_in = 32'(req_ch.plane) >= 32'(CHANNELS);
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            if (x_done && y_done) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_DATA;
         end
         S_DATA: begin
            // hold the read data until the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = bad_plane_ff ? '0 : rdata_wide[SAMPLE_W-1:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         src_w_ff     <= SRC_RESET;
         src_h_ff     <= SRC_RESET;
         dst_w_ff     <= DST_RESET;
         dst_h_ff     <= DST_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         src_w_ff     <= src_w_in;
         src_h_ff     <= src_h_in;
         dst_w_ff     <= dst_w_in;
         dst_h_ff     <= dst_h_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      plane_ff     <= plane_in;
      bad_plane_ff <= bad_plane_in;
   end

   // frame store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr_full[ADDR_W-1:0]] <= PIXEL_BITS'(req_ch.sample_in);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr_full[ADDR_W-1:0]];
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.sample_out = rsp_data_ff;

endmodule

### rtl/core/nnr_checker.sv
module nnr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_mode,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [nnr_pkg::SAMPLE_W-1:0] rsp_sample_out
);
   import nnr_pkg::*;

   logic query_fire;

   assign query_fire = req_valid && req_ready && req_mode;

   // a pending response stays up until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_sample_out))
      else $error("response data changed while stalled");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one query in flight: a query blocks further requests
   assert property (@(posedge clock) disable iff (reset)
      query_fire |=> !req_ready)
      else $error("request taken while a query is in flight");

   assert property (@(posedge clock) disable iff (reset)
      query_fire |=> !$rose(rsp_valid))
      else $error("response appeared right after a query");

endmodule

bind nearest_neighbor_resize nnr_checker u_nnr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_mode       (req_ch.mode),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_sample_out (rsp_ch.sample_out)
);

### tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
   import nnr_pkg::*;

   localparam int MAX_W       = 256;
   localparam int MAX_H       = 256;
   localparam int CHANNELS    = 3;
   localparam int STORE_DEPTH = MAX_W * MAX_H * CHANNELS;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // no register lives at this index
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   localparam int TAIL_CYCLES    = 32;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int MAX_REPORTS    = 100;
   localparam int PHASE_ITEMS    = 200;

   typedef struct {
      logic                mode;
      logic [COORD_W-1:0]  col;
      logic [COORD_W-1:0]  row;
      logic [PLANE_W-1:0]  plane;
      logic [SAMPLE_W-1:0] sample;
   } pixel_req_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   nnr_req_if req_bus ();
   nnr_rsp_if rsp_bus ();

   nearest_neighbor_resize #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H),
      .CHANNELS   (CHANNELS),
      .PIXEL_BITS (SAMPLE_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // size registers as the block holds them
   logic [SRC_W-1:0] cfg_src_w = SRC_RESET;
   logic [SRC_W-1:0] cfg_src_h = SRC_RESET;
   logic [DST_W-1:0] cfg_dst_w = DST_RESET;
   logic [DST_W-1:0] cfg_dst_h = DST_RESET;

   logic [SAMPLE_W-1:0] pix_mem [STORE_DEPTH];
   bit                  gen_written [STORE_DEPTH];

   pixel_req_t          pending_reqs [$];
   pixel_req_t          cur_req;
   logic [SAMPLE_W-1:0] expected_samples [$];

   int send_idle_pct = 30;
   int recv_idle_pct = 69;
   int fail_count    = 0;
   int compared      = 0;
   int sent_count    = 0;
   int query_count   = 0;
   int phase_count   = 0;
   int quiet_cycles  = 0;

   function automatic int unsigned fit_size(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned src_coord(int unsigned d, int unsigned src, int unsigned dst);
      int unsigned scale;
      int unsigned s;
      // shrinking scales by src-1 so the last target pixel stays inside
      scale = (src <= dst) ? src : src - 1;
      s = (d * scale) / dst;
      if (s > src - 1) s = src - 1;
      return s;
   endfunction

   function automatic int unsigned store_addr(int unsigned col, int unsigned row,
                                              int unsigned plane);
      return (plane * MAX_H + row) * MAX_W + col;
   endfunction

   function automatic bit load_in_image(pixel_req_t r);
      return r.col < fit_size(cfg_src_w, MAX_W) && r.row < fit_size(cfg_src_h, MAX_H)
             && r.plane < CHANNELS;
   endfunction

   function automatic int unsigned query_addr(pixel_req_t r);
      int unsigned sx;
      int unsigned sy;
      sx = src_coord(r.col, fit_size(cfg_src_w, MAX_W), fit_size(cfg_dst_w, 13'h1FFF));
      sy = src_coord(r.row, fit_size(cfg_src_h, MAX_H), fit_size(cfg_dst_h, 13'h1FFF));
      return store_addr(sx, sy, r.plane);
   endfunction

   function automatic void apply_request(pixel_req_t r);
      if (r.mode == MODE_LOAD) begin
         if (load_in_image(r)) pix_mem[store_addr(r.col, r.row, r.plane)] = r.sample;
      end else if (r.plane >= CHANNELS) begin
         expected_samples.push_back('0);
      end else begin
         expected_samples.push_back(pix_mem[query_addr(r)]);
      end
   endfunction

   function automatic void push_load(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                                     logic [PLANE_W-1:0] plane, logic [SAMPLE_W-1:0] sample);
      pixel_req_t r;
      r = '{MODE_LOAD, col, row, plane, sample};
      pending_reqs.push_back(r);
      if (load_in_image(r)) gen_written[store_addr(col, row, plane)] = 1'b1;
   endfunction

   // a query never reads an unwritten sample: load it first when needed
   function automatic void push_query(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                                      logic [PLANE_W-1:0] plane);
      pixel_req_t  r;
      int unsigned a;
      r = '{MODE_QUERY, col, row, plane, SAMPLE_W'($urandom)};
      if (plane < CHANNELS) begin
         a = query_addr(r);
         if (!gen_written[a])
            push_load(COORD_W'(a % MAX_W), COORD_W'((a / MAX_W) % MAX_H), plane,
                      SAMPLE_W'($urandom));
      end
      pending_reqs.push_back(r);
   endfunction

   task automatic report_mismatch(string msg);
      if (fail_count < MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            apply_request(cur_req);
            sent_count++;
            if (cur_req.mode == MODE_QUERY) query_count++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               cur_req = pending_reqs.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.mode      <= cur_req.mode;
               req_bus.col       <= cur_req.col;
               req_bus.row       <= cur_req.row;
               req_bus.plane     <= cur_req.plane;
               req_bus.sample_in <= cur_req.sample;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      logic [SAMPLE_W-1:0] want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch($sformatf("sample_out %h with no query pending",
                                         rsp_bus.sample_out));
            end else begin
               want = expected_samples.pop_front();
               compared++;
               if (rsp_bus.sample_out !== want)
                  report_mismatch($sformatf("sample_out %h, want %h", rsp_bus.sample_out, want));
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_SOURCE_WIDTH:  cfg_src_w = data[SRC_W-1:0];
         CSR_SOURCE_HEIGHT: cfg_src_h = data[SRC_W-1:0];
         CSR_TARGET_WIDTH:  cfg_dst_w = data[DST_W-1:0];
         CSR_TARGET_HEIGHT: cfg_dst_h = data[DST_W-1:0];
         default: ;
      endcase
   endtask

   // block drained, then let any load still in the pipe settle
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_bus.valid || expected_samples.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic gen_random(int n);
      int          made;
      int unsigned pick;
      int unsigned sw;
      int unsigned sh;
      int unsigned tw;
      int unsigned th;
      sw = fit_size(cfg_src_w, MAX_W);
      sh = fit_size(cfg_src_h, MAX_H);
      tw = fit_size(fit_size(cfg_dst_w, 13'h1FFF), 4096);
      th = fit_size(fit_size(cfg_dst_h, 13'h1FFF), 4096);
      made = 0;
      while (made < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            push_load(COORD_W'($urandom_range(0, sw - 1)), COORD_W'($urandom_range(0, sh - 1)),
                      PLANE_W'($urandom_range(0, CHANNELS - 1)), SAMPLE_W'($urandom));
            made++;
         end else if (pick < 85) begin
            push_query(COORD_W'($urandom_range(0, tw - 1)), COORD_W'($urandom_range(0, th - 1)),
                       PLANE_W'($urandom_range(0, CHANNELS - 1)));
            made++;
         end else if (pick < 91) begin
            // anywhere, including past the target and the unused plane
            push_query(COORD_W'($urandom), COORD_W'($urandom), PLANE_W'($urandom));
            made++;
         end else if (pick < 97) begin
            push_load(COORD_W'($urandom), COORD_W'($urandom), PLANE_W'($urandom),
                      SAMPLE_W'($urandom));
         end else begin
            push_load(COORD_W'($urandom_range(0, sw - 1)), COORD_W'($urandom_range(0, sh - 1)),
                      PLANE_W'(CHANNELS), SAMPLE_W'($urandom));
         end
      end
   endtask

   task automatic run_phase(int unsigned sw, int unsigned sh, int unsigned tw, int unsigned th,
                            int send_pct, int recv_pct);
      wait_idle();
      write_reg(CSR_SOURCE_WIDTH, CSR_DATA_W'(sw));
      write_reg(CSR_SOURCE_HEIGHT, CSR_DATA_W'(sh));
      write_reg(CSR_TARGET_WIDTH, CSR_DATA_W'(tw));
      write_reg(CSR_TARGET_HEIGHT, CSR_DATA_W'(th));
      write_reg(CSR_UNUSED, CSR_DATA_W'($urandom));
      @(posedge clock);
      csr_we <= 1'b0;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      phase_count++;
      gen_random(PHASE_ITEMS);
   endtask

   initial begin
      int unsigned sw;
      int unsigned sh;
      int unsigned tw;
      int unsigned th;
      csr_we            = 1'b0;
      csr_index         = CSR_SOURCE_WIDTH;
      csr_wdata         = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset sizes: 256 x 256 onto 256 x 256, coordinates map one to one
      push_load(12'd0, 12'd0, 2'd0, 16'h0000);
      push_load(12'd255, 12'd255, 2'd2, 16'hFFFF);
      push_load(12'd255, 12'd0, 2'd1, 16'hA5A5);
      push_load(12'd0, 12'd255, 2'd0, 16'h5A5A);
      push_load(12'd256, 12'd0, 2'd0, 16'h1234);
      push_load(12'd0, 12'hFFF, 2'd1, 16'h4321);
      push_load(12'hFFF, 12'hFFF, 2'd3, 16'hFFFF);
      push_load(12'd7, 12'd7, 2'd3, 16'hBEEF);
      push_query(12'd0, 12'd0, 2'd0);
      push_query(12'd255, 12'd255, 2'd2);
      push_query(12'hFFF, 12'hFFF, 2'd2);
      push_query(12'd255, 12'd0, 2'd1);
      push_query(12'd256, 12'd0, 2'd1);
      push_query(12'd0, 12'd255, 2'd0);
      push_query(12'd3, 12'd3, 2'd3);
      push_query(12'hFFF, 12'hFFF, 2'd3);
      push_load(12'd0, 12'd0, 2'd0, 16'hFFFF);
      push_query(12'd0, 12'd0, 2'd0);

      run_phase(256, 256, 1, 1, 30, 69);
      run_phase(1, 1, 4096, 4096, 30, 69);
      run_phase(16, 9, 40, 20, 30, 69);
      run_phase(20, 12, 7, 5, 30, 69);
      // zero sizes act as one, an all-ones source size acts as the maximum
      run_phase(0, 13'h1FFF, 0, 4095, 69, 30);
      for (int p = 0; p < 5; p++) begin
         sw = ($urandom_range(0, 99) < 15) ? 256 : $urandom_range(1, 24);
         sh = ($urandom_range(0, 99) < 15) ? 256 : $urandom_range(1, 24);
         tw = ($urandom_range(0, 99) < 10) ? 4096 : $urandom_range(1, 64);
         th = ($urandom_range(0, 99) < 10) ? 4096 : $urandom_range(1, 64);
         if (p < 2) run_phase(sw, sh, tw, th, 69, 30);
         else run_phase(sw, sh, tw, th, 0, 0);
      end

      wait_idle();
      $display("%0d requests sent, %0d of them queries, over %0d size settings",
               sent_count, query_count, phase_count + 1);
      $display("%0d samples checked, %0d mismatches", compared, fail_count);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
